### design/nbt_pkg.sv
// Shared types and constants for the neighbor table with aging.
// Used by the configuration registers, the top level and its checker.
package nbt_pkg;

    localparam int DEF_TABLE_ENTRIES = 20;
    localparam logic [31:0] MAX_AGE_RESET = 32'd600;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 2'd1;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_PURGE   = 1'b1;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_OWN      = 3'd3;
    localparam logic [2:0] ST_PURGED   = 3'd4;

    typedef struct packed {
        logic [15:0] own_id;
        logic [31:0] max_age_ms;
    } cfg_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] heading;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OBS,
        S_PRD,
        S_PCHK,
        S_PMOV,
        S_DONE
    } nbt_state_t;

endpackage

### design/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging: sequencer and entry memory.
// Depends on nbt_pkg and nbt_cfg_regs.
//
//  channel | signals                                    | direction
//  input   | in_valid/in_stall, command, now_ms,        | in
//          | src_id, heading_mrad                       |
//  result  | out_valid/out_stall, status, entry_count,  | out
//          | removed_count                              |
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data   | in
//
// An own-id observe or a purge of an empty table goes from S_IDLE straight to S_DONE, which loads the result.
// Other observes sweep the entries through the single read port of the entry
// memory, one entry a cycle. A purge reads and checks each entry from the last
// slot down, and refills each stale entry from the last one.
// Reset clears the state, the entry count, out_valid and the pending flag; the memory holds no reset value.
// in_stall is high while an item is in work; a stalled result holds in its register.
module neighbor_table_with_aging
    import nbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [31:0]          now_ms,
    input  logic [15:0]          src_id,
    input  logic signed [15:0]   heading_mrad,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [6:0]           entry_count,
    output logic [6:0]           removed_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    cfg_t cfg;

    nbt_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    // Entry memory: one write port, one registered read port.
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    nbt_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [2:0]       result_reg, result_next;
    logic             cmd_reg;
    logic [31:0]      now_reg;
    logic [15:0]      id_reg;
    logic [15:0]      head_reg;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg;
    logic [6:0]       out_count_reg;
    logic [6:0]       out_removed_reg;

    logic             accept;
    logic             own_hit;
    logic             id_match;
    logic             stale;
    logic             slot_is_last;
    logic             out_free;
    logic [31:0]      age;

    assign accept       = in_valid && (state_reg == S_IDLE);
    assign own_hit      = (src_id == cfg.own_id);
    assign id_match     = pend_reg && (rd_data_reg.id == id_reg);
    assign age          = now_reg - rd_data_reg.stamp;
    assign stale        = (age > cfg.max_age_ms);
    assign slot_is_last = (CNT_W'(slot_reg) == count_reg - CNT_W'(1));
    assign out_free     = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_PURGE)
                    begin
                        state_next = (count_reg == '0) ? S_DONE : S_PRD;
                    end
                    else
                    begin
                        state_next = own_hit ? S_DONE : S_OBS;
                    end
                end
            end
            S_OBS:
            begin
                if (id_match || (idx_reg >= count_reg))
                begin
                    state_next = S_DONE;
                end
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (stale && !slot_is_last)
                begin
                    state_next = S_PMOV;
                end
                else
                begin
                    state_next = (slot_reg == '0) ? S_DONE : S_PRD;
                end
            end
            S_PMOV:
            begin
                state_next = (slot_reg == '0) ? S_DONE : S_PRD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory control and datapath.
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_data        = rd_data_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        slot_next      = slot_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                idx_next     = '0;
                removed_next = '0;
                slot_next    = AW'(count_reg - CNT_W'(1));
                if (command == CMD_PURGE)
                begin
                    result_next = ST_PURGED;
                end
                else
                begin
                    result_next = ST_OWN;
                end
            end
            S_OBS:
            begin
                if (id_match)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = pend_addr_reg;
                    wr_data     = '{id: id_reg, heading: head_reg, stamp: now_reg};
                    result_next = ST_UPDATED;
                end
                else if (idx_reg < count_reg)
                begin
                    // Read the next entry while the previous one is compared.
                    rd_en          = 1'b1;
                    rd_addr        = idx_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else if (count_reg >= FULL_COUNT)
                begin
                    result_next = ST_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = count_reg[AW-1:0];
                    wr_data     = '{id: id_reg, heading: head_reg, stamp: now_reg};
                    count_next  = count_reg + CNT_W'(1);
                    result_next = ST_INSERTED;
                end
            end
            S_PRD:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_reg;
            end
            S_PCHK:
            begin
                if (stale && !slot_is_last)
                begin
                    // Fetch the last entry to refill the freed slot.
                    rd_en   = 1'b1;
                    rd_addr = AW'(count_reg - CNT_W'(1));
                end
                else
                begin
                    if (stale)
                    begin
                        count_next   = count_reg - CNT_W'(1);
                        removed_next = removed_reg + CNT_W'(1);
                    end
                    if (slot_reg != '0)
                    begin
                        slot_next = slot_reg - AW'(1);
                    end
                end
            end
            S_PMOV:
            begin
                wr_en        = 1'b1;
                wr_addr      = slot_reg;
                wr_data      = rd_data_reg;
                count_next   = count_reg - CNT_W'(1);
                removed_next = removed_reg + CNT_W'(1);
                if (slot_reg != '0)
                begin
                    slot_next = slot_reg - AW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg   <= removed_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        slot_reg      <= slot_next;
        result_reg    <= result_next;
        if (accept)
        begin
            cmd_reg  <= command;
            now_reg  <= now_ms;
            id_reg   <= src_id;
            head_reg <= heading_mrad;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_status_reg  <= result_reg;
            out_count_reg   <= 7'(count_reg);
            out_removed_reg <= (cmd_reg == CMD_PURGE) ? 7'(removed_reg) : 7'd0;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;
    assign removed_count = out_removed_reg;

endmodule

### design/nbt_cfg_regs.sv
// Configuration registers of the neighbor table: own id and age limit.
// Depends on nbt_pkg for the register indexes and the cfg_t struct.
module nbt_cfg_regs
    import nbt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 cfg_ready,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Users must write only while the table is idle; not checked, all are taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id     <= 16'd0;
            cfg_reg.max_age_ms <= MAX_AGE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_ID:  cfg_reg.own_id     <= cfg_data[15:0];
                CFG_MAX_AGE: cfg_reg.max_age_ms <= cfg_data;
                default:     ;
            endcase
        end
    end

endmodule

### design/nbt_checker.sv
// Port-level checker for the neighbor table with aging, bound to the top level.
// Depends on nbt_pkg for the status codes.
module nbt_checker
    import nbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic [6:0] entry_count,
    input logic [6:0] removed_count
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(entry_count) && $stable(removed_count))
        else $error("stalled result transaction changed");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 7'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_removed_only_purge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_PURGED) |-> removed_count == 7'd0)
        else $error("removed count nonzero on an observe");

    a_insert_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INSERTED || status == ST_UPDATED)
            |-> entry_count != 7'd0)
        else $error("table empty after insert or update");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_PURGED)
        else $error("status code out of range");

endmodule

bind neighbor_table_with_aging nbt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_nbt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_count   (entry_count),
    .removed_count (removed_count)
);
